[rtl/rau_pkg.sv]
// Shared types and constants for the rational arithmetic unit.
// Depends on nothing; every other file of the block imports it.
package rau_pkg;

    localparam int WIDTH = 32;
    localparam int DW    = 2 * WIDTH;
    localparam int NUM_W = 32;
    localparam int DEN_W = 31;
    localparam int CW    = $clog2(DW + 1);

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    localparam logic [1:0] ORD_LT = 2'd0;
    localparam logic [1:0] ORD_EQ = 2'd1;
    localparam logic [1:0] ORD_GT = 2'd2;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        CLS_SKIP,
        CLS_ERR,
        CLS_RUN
    } cls_t;

    typedef struct packed {
        logic [2:0]       kind;
        logic [NUM_W-1:0] a_num;
        logic [DEN_W-1:0] a_den;
        logic [NUM_W-1:0] b_num;
        logic [DEN_W-1:0] b_den;
    } req_t;

    typedef struct packed {
        logic [NUM_W-1:0] res_num;
        logic [DEN_W-1:0] res_den;
        logic [1:0]       status;
        logic [1:0]       order;
    } rsp_t;

    typedef struct packed {
        op_t              op;
        cls_t             cls;
        logic [WIDTH-1:0] an;
        logic [WIDTH-2:0] ad;
        logic [WIDTH-1:0] bn;
        logic [WIDTH-2:0] bd;
    } job_t;

endpackage

[rtl/rau_front.sv]
// Front end: accepts a transaction, classifies it and queues it for the back end.
// Depends on rau_pkg.
module rau_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t req,
    output logic          q_valid,
    output rau_pkg::job_t q_job,
    input  logic          q_pop
);
    import rau_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    job_t       job_in;

    always_comb
    begin
        job_in.an = req.a_num[WIDTH-1:0];
        job_in.ad = req.a_den[WIDTH-2:0];
        job_in.bn = req.b_num[WIDTH-1:0];
        job_in.bd = req.b_den[WIDTH-2:0];
        case (req.kind)
            OP_ADD:  job_in.op = OP_ADD;
            OP_SUB:  job_in.op = OP_SUB;
            OP_MUL:  job_in.op = OP_MUL;
            OP_DIV:  job_in.op = OP_DIV;
            OP_CMP:  job_in.op = OP_CMP;
            default: job_in.op = OP_ADD;
        endcase
        if (req.kind > OP_CMP)
        begin
            job_in.cls = CLS_SKIP;
        end
        else if (job_in.ad == '0 || job_in.bd == '0 || (req.kind == OP_DIV && job_in.bn == '0))
        begin
            job_in.cls = CLS_ERR;
        end
        else
        begin
            job_in.cls = CLS_RUN;
        end
    end

    assign busy    = (count_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (count_reg != 2'd0);
    assign q_job   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end

endmodule

[rtl/rau_back.sv]
// Back end: cross products on one shared multiplier, binary GCD and two
// bit-serial dividers that reduce the fraction. Depends on rau_pkg.
module rau_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_valid,
    input  rau_pkg::job_t q_job,
    output logic          q_pop,
    output logic          done,
    output rau_pkg::rsp_t rsp
);
    import rau_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_FORM,
        S_GCD,
        S_DIV,
        S_CHECK
    } state_t;

    localparam logic [DW-1:0] LIM = DW'(1) << (WIDTH - 1);

    state_t               state_reg;
    job_t                 job_reg;
    logic [DW-1:0]        t0_reg;
    logic [DW-1:0]        t1_reg;
    logic [DW-1:0]        t2_reg;
    logic                 neg_reg;
    logic [DW-1:0]        nm_reg;
    logic [DW-1:0]        dm_reg;
    logic [DW-1:0]        gx_reg;
    logic [DW-1:0]        gy_reg;
    logic [DW-1:0]        g_reg;
    logic [CW-1:0]        k_reg;
    logic [CW-1:0]        cnt_reg;
    logic [DW:0]          rn_reg;
    logic [DW:0]          rd_reg;
    logic                 done_reg;
    rsp_t                 rsp_reg;

    logic signed [WIDTH:0]     ma;
    logic signed [WIDTH:0]     mb;
    logic signed [2*WIDTH+1:0] prod;
    logic [WIDTH:0]            an_x;
    logic [WIDTH:0]            bn_x;
    logic [WIDTH:0]            ad_x;
    logic [WIDTH:0]            bd_x;
    logic [DW-1:0]             n_w;
    logic [DW-1:0]             d_w;
    logic [DW:0]               rn_sh;
    logic [DW:0]               rd_sh;
    logic [DW:0]               g_x;
    logic [WIDTH-1:0]          num_w;

    assign an_x = {job_reg.an[WIDTH-1], job_reg.an};
    assign bn_x = {job_reg.bn[WIDTH-1], job_reg.bn};
    assign ad_x = {2'b00, job_reg.ad};
    assign bd_x = {2'b00, job_reg.bd};

    always_comb
    begin
        case (state_reg)
            S_MUL0:
            begin
                ma = signed'(an_x);
                mb = (job_reg.op == OP_MUL) ? signed'(bn_x) : signed'(bd_x);
            end
            S_MUL1:
            begin
                ma = signed'(ad_x);
                mb = (job_reg.op == OP_MUL) ? signed'(bd_x) : signed'(bn_x);
            end
            default:
            begin
                ma = signed'(ad_x);
                mb = signed'(bd_x);
            end
        endcase
        prod = ma * mb;
    end

    always_comb
    begin
        case (job_reg.op)
            OP_ADD:  n_w = t0_reg + t1_reg;
            OP_MUL:  n_w = t0_reg;
            OP_DIV:  n_w = t0_reg;
            default: n_w = t0_reg - t1_reg;
        endcase
        d_w = (job_reg.op == OP_ADD || job_reg.op == OP_SUB) ? t2_reg : t1_reg;
    end

    assign g_x   = {1'b0, g_reg};
    assign rn_sh = {rn_reg[DW-1:0], nm_reg[DW-1]};
    assign rd_sh = {rd_reg[DW-1:0], dm_reg[DW-1]};
    assign num_w = neg_reg ? WIDTH'(-nm_reg) : nm_reg[WIDTH-1:0];

    assign q_pop = (state_reg == S_IDLE) && q_valid;
    assign done  = done_reg;
    assign rsp   = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg        <= 1'b0;
            rsp_reg.res_num <= '0;
            rsp_reg.res_den <= DEN_W'(1);
            rsp_reg.status  <= ST_OK;
            rsp_reg.order   <= ORD_LT;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg <= q_job;
                        case (q_job.cls)
                            CLS_SKIP:
                            begin
                                done_reg <= 1'b1;
                            end
                            CLS_ERR:
                            begin
                                done_reg       <= 1'b1;
                                rsp_reg.status <= ST_DIVZ;
                            end
                            default:
                            begin
                                state_reg <= S_MUL0;
                            end
                        endcase
                    end
                end
                S_MUL0:
                begin
                    t0_reg    <= prod[DW-1:0];
                    state_reg <= S_MUL1;
                end
                S_MUL1:
                begin
                    t1_reg    <= prod[DW-1:0];
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    t2_reg    <= prod[DW-1:0];
                    state_reg <= S_FORM;
                end
                S_FORM:
                begin
                    neg_reg <= n_w[DW-1] ^ d_w[DW-1];
                    nm_reg  <= n_w[DW-1] ? -n_w : n_w;
                    dm_reg  <= d_w[DW-1] ? -d_w : d_w;
                    gx_reg  <= n_w[DW-1] ? -n_w : n_w;
                    gy_reg  <= d_w[DW-1] ? -d_w : d_w;
                    k_reg   <= '0;
                    if (job_reg.op == OP_CMP)
                    begin
                        done_reg      <= 1'b1;
                        rsp_reg.order <= n_w[DW-1] ? ORD_LT : ((n_w == '0) ? ORD_EQ : ORD_GT);
                        state_reg     <= S_IDLE;
                    end
                    else if (n_w == '0)
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    if (gx_reg == '0)
                    begin
                        g_reg     <= gy_reg << k_reg;
                        rn_reg    <= '0;
                        rd_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                    else if (!gx_reg[0] && !gy_reg[0])
                    begin
                        gx_reg <= gx_reg >> 1;
                        gy_reg <= gy_reg >> 1;
                        k_reg  <= k_reg + CW'(1);
                    end
                    else if (!gx_reg[0])
                    begin
                        gx_reg <= gx_reg >> 1;
                    end
                    else if (!gy_reg[0])
                    begin
                        gy_reg <= gy_reg >> 1;
                    end
                    else if (gx_reg >= gy_reg)
                    begin
                        gx_reg <= (gx_reg - gy_reg) >> 1;
                    end
                    else
                    begin
                        gy_reg <= (gy_reg - gx_reg) >> 1;
                    end
                end
                S_DIV:
                begin
                    if (rn_sh >= g_x)
                    begin
                        rn_reg <= rn_sh - g_x;
                        nm_reg <= {nm_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rn_reg <= rn_sh;
                        nm_reg <= {nm_reg[DW-2:0], 1'b0};
                    end
                    if (rd_sh >= g_x)
                    begin
                        rd_reg <= rd_sh - g_x;
                        dm_reg <= {dm_reg[DW-2:0], 1'b1};
                    end
                    else
                    begin
                        rd_reg <= rd_sh;
                        dm_reg <= {dm_reg[DW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(DW - 1))
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (dm_reg >= LIM || (neg_reg ? nm_reg > LIM : nm_reg >= LIM))
                    begin
                        rsp_reg.status <= ST_OVF;
                    end
                    else
                    begin
                        rsp_reg.res_num <= NUM_W'(signed'(num_w));
                        rsp_reg.res_den <= DEN_W'(dm_reg[WIDTH-2:0]);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/rational_arith_unit.sv]
// Top level of the rational arithmetic unit: front end, job queue, back end.
// Depends on rau_pkg, rau_front and rau_back.
//
//   channel   handshake          payload
//   request   start / busy       req   (req_t fields: kind, a_num, a_den, b_num, b_den)
//   result    done (one cycle)   rsp   (res_num, res_den, status, order)
//
// A reduced operation runs the products, the binary GCD (one step a cycle)
// and the two bit-serial dividers. Errors and unused kinds finish without
// the products; compares skip the GCD and the dividers.
// Reset clears the queue and the sequencer. busy rises only when the
// two-entry queue is full; results cannot be held off by the receiver.
module rational_arith_unit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  rau_pkg::req_t req,
    output logic          done,
    output rau_pkg::rsp_t rsp
);
    import rau_pkg::*;

    logic q_valid;
    logic q_pop;
    job_t q_job;

    rau_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop)
    );

    rau_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .done    (done),
        .rsp     (rsp)
    );

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (rsp.status == ST_OK || rsp.status == ST_DIVZ || rsp.status == ST_OVF))
        else $error("invalid status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.status != ST_OK) |-> (rsp.res_num == '0 && rsp.res_den == DEN_W'(1)
            && rsp.order == ORD_LT))
        else $error("error result not cleared");

    a_den_positive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> rsp.res_den != '0)
        else $error("zero denominator delivered");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

endmodule

[test/rau_checker.sv]
// Checker for the rational arithmetic unit: watches the request and result channels,
// predicts each result and compares it field by field. Depends on rau_pkg.
module rau_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          busy,
    input  rau_pkg::req_t req,
    input  logic          done,
    input  rau_pkg::rsp_t rsp,
    output int            errors,
    output int            pending
);
    import rau_pkg::*;

    rsp_t expected_q[$];

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        return x;
    endfunction

    function automatic rsp_t reduce_fraction(req_t t);
        rsp_t o;
        longint an, bn, ad, bd, n, d, diff;
        logic [63:0] nm, dm, g;
        logic neg;
        an = longint'(signed'(t.a_num));
        bn = longint'(signed'(t.b_num));
        ad = longint'({33'd0, t.a_den});
        bd = longint'({33'd0, t.b_den});
        o = '{res_num: '0, res_den: 31'd1, status: ST_OK, order: ORD_LT};
        if (t.kind > OP_CMP)
            return o;
        if (ad == 0 || bd == 0 || (t.kind == OP_DIV && bn == 0))
        begin
            o.status = ST_DIVZ;
            return o;
        end
        if (t.kind == OP_CMP)
        begin
            diff = an * bd - bn * ad;
            o.order = diff < 0 ? ORD_LT : (diff == 0 ? ORD_EQ : ORD_GT);
            return o;
        end
        case (t.kind)
            OP_ADD:  begin n = an * bd + bn * ad; d = ad * bd; end
            OP_SUB:  begin n = an * bd - bn * ad; d = ad * bd; end
            OP_MUL:  begin n = an * bn; d = ad * bd; end
            default: begin n = an * bd; d = ad * bn; end
        endcase
        neg = (n < 0) != (d < 0);
        nm = n < 0 ? -n : n;
        dm = d < 0 ? -d : d;
        if (nm == 0)
            return o;
        g = gcd64(nm, dm);
        nm = nm / g;
        dm = dm / g;
        if (dm > 64'h7FFF_FFFF || (neg ? nm > 64'h8000_0000 : nm > 64'h7FFF_FFFF))
        begin
            o.status = ST_OVF;
            return o;
        end
        o.res_num = neg ? -nm[31:0] : nm[31:0];
        o.res_den = dm[30:0];
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            errors <= 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, rsp);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want !== rsp)
                    begin
                        $display("%0t: expected num %0d den %0d st %0d ord %0d, got num %0d den %0d st %0d ord %0d",
                                 $time, signed'(want.res_num), want.res_den, want.status,
                                 want.order, signed'(rsp.res_num), rsp.res_den, rsp.status,
                                 rsp.order);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(reduce_fraction(req));
        end
    end
endmodule

[test/tb_rational_arith_unit.sv]
// Testbench top for the rational arithmetic unit: drives directed and random transactions
// with idle phases and gives the verdict. Depends on rau_pkg, rational_arith_unit and rau_checker.
module tb_rational_arith_unit;
    import rau_pkg::*;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t req;
    logic done;
    rsp_t rsp;
    int   errors;
    int   pending;
    int   idle_pct;
    int   quiet_cycles;
    logic timed_out;

    localparam int WATCHDOG_LIMIT = 20000;

    rational_arith_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req(req), .done(done), .rsp(rsp)
    );

    rau_checker checker_i (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .req(req),
        .done(done), .rsp(rsp), .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out <= 1'b1;
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [31:0] pick_num();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(signed'($urandom_range(0, 40)) - 20);
            3: return 32'(signed'($urandom_range(0, 2000)) - 1000);
            4: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] pick_den();
        case ($urandom_range(0, 9))
            0: return 31'h7FFF_FFFF;
            1: return 31'd1;
            2: return 31'($urandom_range(1, 12));
            3: return 31'($urandom_range(1, 1000));
            4: return 31'($urandom_range(1, 100000));
            5: return 31'd0;
            default: return 31'($urandom);
        endcase
    endfunction

    task automatic send(logic [2:0] kind, logic [31:0] an, logic [30:0] ad,
                        logic [31:0] bn, logic [30:0] bd);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start <= 1'b1;
        req <= '{kind: kind, a_num: an, a_den: ad, b_num: bn, b_den: bd};
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int n;
        logic [2:0] k;
        logic [31:0] x;
        timed_out = 1'b0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        idle_pct = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send(OP_ADD, 32'd1, 31'd2, 32'd1, 31'd3);
        send(OP_SUB, 32'd1, 31'd2, 32'd1, 31'd2);
        send(OP_MUL, 32'h8000_0000, 31'd1, 32'h8000_0000, 31'd1);
        send(OP_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send(OP_MUL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFF);
        send(OP_DIV, 32'd3, 31'd4, 32'd0, 31'd5);
        send(OP_DIV, 32'd3, 31'd4, 32'hFFFF_FFFD, 31'd8);
        send(OP_DIV, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send(OP_ADD, 32'd1, 31'd0, 32'd1, 31'd1);
        send(OP_CMP, 32'd1, 31'd1, 32'd1, 31'd0);
        send(OP_CMP, 32'd1, 31'd2, 32'd2, 31'd4);
        send(OP_CMP, 32'hFFFF_FFFF, 31'd2, 32'd1, 31'd2);
        send(OP_CMP, 32'h7FFF_FFFF, 31'd1, 32'h8000_0000, 31'd1);
        send(OP_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send(OP_SUB, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send(3'd5, 32'd1, 31'd1, 32'd1, 31'd1);
        send(3'd7, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 53 : (phase == 3 ? 10 : 0);
            for (n = 0; n < 435; n++)
            begin
                k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                 : 3'($urandom_range(0, 4));
                x = pick_num();
                send(k, x, pick_den(), ($urandom_range(0, 9) == 0) ? x : pick_num(),
                     pick_den());
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
